// ===== rtl/dlpe_pkg.sv =====
// shared constants and types for the line program encoder
package dlpe_pkg;

   // field widths
   localparam int LINE_BITS = 24;
   localparam int FILE_BITS = 16;
   localparam int ADDR_BITS = 64;

   // leb128 sizing: unsigned file index, signed line delta one bit wider than a line
   localparam int ULEB_BYTES = (FILE_BITS + 6) / 7;
   localparam int ULEB_W = ULEB_BYTES * 7;
   localparam int SLEB_BITS = LINE_BITS + 1;
   localparam int SLEB_BYTES = (SLEB_BITS + 6) / 7;
   localparam int SLEB_W = SLEB_BYTES * 7;
   localparam int ULEB_LEN_W = $clog2(ULEB_BYTES + 1);
   localparam int SLEB_LEN_W = $clog2(SLEB_BYTES + 1);

   // byte stream sizing
   localparam int ADDR_BYTES = ADDR_BITS / 8;
   localparam int SET_ADDR_BYTES = ADDR_BYTES + 3;
   localparam int END_SEQ_BYTES = 3;
   localparam int MAX_BYTES = SET_ADDR_BYTES + ULEB_BYTES + SLEB_BYTES + 4;
   localparam int FRAME_W = MAX_BYTES * 8;
   localparam int COUNT_W = $clog2(MAX_BYTES + 1);

   // item kinds
   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_ROW   = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // opcodes and extended opcode framing
   localparam logic [7:0] OP_EXTENDED       = 8'h00;
   localparam logic [7:0] OP_COPY           = 8'h01;
   localparam logic [7:0] OP_ADVANCE_LINE   = 8'h03;
   localparam logic [7:0] OP_SET_FILE       = 8'h04;
   localparam logic [7:0] OP_BODY_START     = 8'h0a;
   localparam logic [7:0] EXT_SET_ADDR_LEN  = 8'h09;
   localparam logic [7:0] EXT_SET_ADDRESS   = 8'h02;
   localparam logic [7:0] EXT_END_SEQ_LEN   = 8'h01;
   localparam logic [7:0] EXT_END_SEQUENCE  = 8'h01;

endpackage

// ===== rtl/dwarf_line_program_encoder.sv =====
// line program encoder: turns line-table rows into a dwarf v4 line program byte stream
//
// Each accepted item is encoded in full in the cycle it is taken and loaded into a
// byte frame register, which then shifts out one byte per cycle while rsp_ready is
// high on the rsp channel; rsp_last marks the final byte of an item. An end item has
// 14 bytes and a begin or row item 12 to 22, depending on whether the file and line
// change and on the leb128 lengths. The next item is taken in the same cycle as the
// previous item's last byte transfer, so a steady stream with rsp_ready held high runs
// at exactly one byte per cycle. An item of the unused kind 3 is taken and produces
// no bytes.
module dwarf_line_program_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [dlpe_pkg::ADDR_BITS-1:0]  req_address,
   input  logic                            req_has_location,
   input  logic [dlpe_pkg::FILE_BITS-1:0]  req_file_index,
   input  logic [dlpe_pkg::LINE_BITS-1:0]  req_line_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last
);

   // sequence state
   logic [dlpe_pkg::FILE_BITS-1:0] cur_file_ff, cur_file_in;
   logic [dlpe_pkg::LINE_BITS-1:0] cur_line_ff, cur_line_in;
   logic                           prologue_done_ff, prologue_done_in;

   // output frame
   logic [dlpe_pkg::FRAME_W-1:0]   frame_ff, frame_in;
   logic [dlpe_pkg::COUNT_W-1:0]   count_ff, count_in;

   // encoder signals
   logic                             req_xfer;
   logic                             rsp_xfer;
   logic                             emit_row;
   logic [dlpe_pkg::FILE_BITS-1:0]   base_file;
   logic [dlpe_pkg::LINE_BITS-1:0]   base_line;
   logic [dlpe_pkg::FILE_BITS-1:0]   file_eff;
   logic [dlpe_pkg::LINE_BITS-1:0]   line_eff;
   logic                             mark_prologue;
   logic                             file_chg;
   logic                             line_chg;
   logic [dlpe_pkg::ULEB_W-1:0]      file_ext;
   logic [dlpe_pkg::ULEB_BYTES*8-1:0] uleb_vec;
   logic [dlpe_pkg::ULEB_LEN_W-1:0]  uleb_len;
   logic [dlpe_pkg::SLEB_W-1:0]      delta;
   logic [dlpe_pkg::SLEB_BYTES*8-1:0] sleb_vec;
   logic [dlpe_pkg::SLEB_LEN_W-1:0]  sleb_len;
   logic [dlpe_pkg::SET_ADDR_BYTES*8-1:0] set_addr_vec;
   logic [dlpe_pkg::FRAME_W-1:0]     enc_frame;
   logic [dlpe_pkg::COUNT_W-1:0]     enc_count;

   // handshakes
   assign rsp_valid    = (count_ff != '0);
   assign rsp_out_byte = frame_ff[7:0];
   assign rsp_last     = (count_ff == dlpe_pkg::COUNT_W'(1));
   assign rsp_xfer     = rsp_valid && rsp_ready;
   assign req_ready    = !rsp_valid || (rsp_last && rsp_ready);
   assign req_xfer     = req_valid && req_ready;

   // per-kind selection of the row being encoded and the state it is measured against
   always_comb begin
      emit_row         = 1'b0;
      base_file        = cur_file_ff;
      base_line        = cur_line_ff;
      file_eff         = req_file_index;
      line_eff         = req_line_number;
      mark_prologue    = 1'b0;
      cur_file_in      = cur_file_ff;
      cur_line_in      = cur_line_ff;
      prologue_done_in = prologue_done_ff;
      unique case (req_kind)
         dlpe_pkg::KIND_BEGIN: begin
            emit_row         = 1'b1;
            base_file        = dlpe_pkg::FILE_BITS'(1);
            base_line        = dlpe_pkg::LINE_BITS'(1);
            cur_file_in      = file_eff;
            cur_line_in      = line_eff;
            prologue_done_in = 1'b0;
         end
         dlpe_pkg::KIND_ROW: begin
            emit_row = 1'b1;
            if (!req_has_location) begin
               file_eff = cur_file_ff;
               line_eff = '0;
            end
            mark_prologue    = !prologue_done_ff && (line_eff != '0);
            cur_file_in      = file_eff;
            cur_line_in      = line_eff;
            prologue_done_in = prologue_done_ff || mark_prologue;
         end
         default: begin
            emit_row = 1'b0;
         end
      endcase
   end

   assign file_chg = (file_eff != base_file);
   assign line_chg = (line_eff != base_line);

   // uleb128 of the file index, lowest group first
   always_comb begin
      file_ext = dlpe_pkg::ULEB_W'(file_eff);
      uleb_len = dlpe_pkg::ULEB_LEN_W'(1);
      uleb_vec = '0;
      for (int i = 0; i < dlpe_pkg::ULEB_BYTES; i++) begin
         uleb_vec[8*i +: 7] = file_ext[7*i +: 7];
         uleb_vec[8*i + 7]  = ((file_ext >> (7*(i+1))) != '0);
         if (uleb_vec[8*i + 7]) begin
            uleb_len = dlpe_pkg::ULEB_LEN_W'(i + 2);
         end
      end
   end

   // sleb128 of the line delta; a group ends the number when all bits above its sign agree
   always_comb begin
      delta    = dlpe_pkg::SLEB_W'(line_eff) - dlpe_pkg::SLEB_W'(base_line);
      sleb_len = dlpe_pkg::SLEB_LEN_W'(dlpe_pkg::SLEB_BYTES);
      sleb_vec = '0;
      for (int i = dlpe_pkg::SLEB_BYTES - 1; i >= 0; i--) begin
         if (((delta >> (7*i + 6)) == '0) ||
             ((delta >> (7*i + 6)) == ({dlpe_pkg::SLEB_W{1'b1}} >> (7*i + 6)))) begin
            sleb_len = dlpe_pkg::SLEB_LEN_W'(i + 1);
         end
      end
      for (int i = 0; i < dlpe_pkg::SLEB_BYTES; i++) begin
         if (i < int'(sleb_len)) begin
            sleb_vec[8*i +: 7] = delta[7*i +: 7];
            sleb_vec[8*i + 7]  = ((i + 1) < int'(sleb_len));
         end
      end
   end

   // set_address opcode with little-endian address
   assign set_addr_vec = {req_address, dlpe_pkg::EXT_SET_ADDRESS,
                          dlpe_pkg::EXT_SET_ADDR_LEN, dlpe_pkg::OP_EXTENDED};

   // pack the byte stream, built back to front, first byte in the low bits
   always_comb begin
      enc_frame = dlpe_pkg::FRAME_W'(dlpe_pkg::OP_COPY);
      enc_count = dlpe_pkg::COUNT_W'(1);
      if (mark_prologue) begin
         enc_frame = (enc_frame << 8) | dlpe_pkg::FRAME_W'(dlpe_pkg::OP_BODY_START);
         enc_count = enc_count + dlpe_pkg::COUNT_W'(1);
      end
      if (line_chg) begin
         enc_frame = (enc_frame << {sleb_len, 3'b000}) | dlpe_pkg::FRAME_W'(sleb_vec);
         enc_frame = (enc_frame << 8) | dlpe_pkg::FRAME_W'(dlpe_pkg::OP_ADVANCE_LINE);
         enc_count = enc_count + dlpe_pkg::COUNT_W'(sleb_len) + dlpe_pkg::COUNT_W'(1);
      end
      if (file_chg) begin
         enc_frame = (enc_frame << {uleb_len, 3'b000}) | dlpe_pkg::FRAME_W'(uleb_vec);
         enc_frame = (enc_frame << 8) | dlpe_pkg::FRAME_W'(dlpe_pkg::OP_SET_FILE);
         enc_count = enc_count + dlpe_pkg::COUNT_W'(uleb_len) + dlpe_pkg::COUNT_W'(1);
      end
      enc_frame = (enc_frame << (dlpe_pkg::SET_ADDR_BYTES * 8)) |
                  dlpe_pkg::FRAME_W'(set_addr_vec);
      enc_count = enc_count + dlpe_pkg::COUNT_W'(dlpe_pkg::SET_ADDR_BYTES);
      // end item and unused kind replace the row stream
      if (!emit_row) begin
         if (req_kind == dlpe_pkg::KIND_END) begin
            enc_frame = (dlpe_pkg::FRAME_W'({dlpe_pkg::EXT_END_SEQUENCE,
                                             dlpe_pkg::EXT_END_SEQ_LEN,
                                             dlpe_pkg::OP_EXTENDED})
                         << (dlpe_pkg::SET_ADDR_BYTES * 8)) |
                        dlpe_pkg::FRAME_W'(set_addr_vec);
            enc_count = dlpe_pkg::COUNT_W'(dlpe_pkg::SET_ADDR_BYTES +
                                           dlpe_pkg::END_SEQ_BYTES);
         end else begin
            enc_count = '0;
         end
      end
   end

   // frame load on input transfer, shift on output transfer
   always_comb begin
      frame_in = frame_ff;
      count_in = count_ff;
      priority if (req_xfer) begin
         frame_in = enc_frame;
         count_in = enc_count;
      end else if (rsp_xfer) begin
         frame_in = frame_ff >> 8;
         count_in = count_ff - dlpe_pkg::COUNT_W'(1);
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         cur_file_ff      <= dlpe_pkg::FILE_BITS'(1);
         cur_line_ff      <= dlpe_pkg::LINE_BITS'(1);
         prologue_done_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_xfer) begin
            cur_file_ff      <= cur_file_in;
            cur_line_ff      <= cur_line_in;
            prologue_done_ff <= prologue_done_in;
         end
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

endmodule

// ===== tb/sv/tb_dwarf_line_program_encoder.sv =====
// testbench for the line program encoder: random and directed rows checked byte by byte
module tb_dwarf_line_program_encoder;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS_PER_MODE = 32;

   // expected byte stream of the line program, built as items are accepted
   class line_program_checker;
      logic [dlpe_pkg::FILE_BITS-1:0] cur_file;
      logic [dlpe_pkg::LINE_BITS-1:0] cur_line;
      bit prologue_seen;
      logic [7:0] expected_bytes[$];
      bit expected_last[$];
      int errors;

      function new();
         cur_file = dlpe_pkg::FILE_BITS'(1);
         cur_line = dlpe_pkg::LINE_BITS'(1);
         prologue_seen = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void put_byte(logic [7:0] b);
         expected_bytes.push_back(b);
         expected_last.push_back(1'b0);
      endfunction

      function void put_uleb(logic [dlpe_pkg::FILE_BITS-1:0] v);
         logic [7:0] b;
         do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0) b[7] = 1'b1;
            put_byte(b);
         end while (v != 0);
      endfunction

      // v is a 64-bit two's complement value
      function void put_sleb(logic [63:0] v);
         logic [7:0] b;
         logic sign;
         logic more;
         more = 1'b1;
         while (more) begin
            b = {1'b0, v[6:0]};
            sign = v[6];
            v = {{7{v[63]}}, v[63:7]};
            more = !((v == 64'd0 && !sign) || (v == '1 && sign));
            if (more) b[7] = 1'b1;
            put_byte(b);
         end
      endfunction

      function void put_set_address(logic [dlpe_pkg::ADDR_BITS-1:0] addr);
         put_byte(dlpe_pkg::OP_EXTENDED);
         put_byte(dlpe_pkg::EXT_SET_ADDR_LEN);
         put_byte(dlpe_pkg::EXT_SET_ADDRESS);
         for (int i = 0; i < dlpe_pkg::ADDR_BYTES; i++) put_byte(addr[8*i +: 8]);
      endfunction

      function void encode_row(logic [dlpe_pkg::FILE_BITS-1:0] file,
                               logic [dlpe_pkg::LINE_BITS-1:0] line,
                               bit mark_prologue);
         logic [63:0] delta;
         if (file != cur_file) begin
            put_byte(dlpe_pkg::OP_SET_FILE);
            put_uleb(file);
            cur_file = file;
         end
         if (line != cur_line) begin
            delta = {{(64-dlpe_pkg::LINE_BITS){1'b0}}, line} -
                    {{(64-dlpe_pkg::LINE_BITS){1'b0}}, cur_line};
            put_byte(dlpe_pkg::OP_ADVANCE_LINE);
            put_sleb(delta);
            cur_line = line;
         end
         if (mark_prologue && !prologue_seen && line != 0) begin
            put_byte(dlpe_pkg::OP_BODY_START);
            prologue_seen = 1;
         end
         put_byte(dlpe_pkg::OP_COPY);
      endfunction

      // accepted input transfer: append the bytes it must produce
      function void note_item(logic [1:0] kind, logic [dlpe_pkg::ADDR_BITS-1:0] addr,
                              logic has_loc, logic [dlpe_pkg::FILE_BITS-1:0] file,
                              logic [dlpe_pkg::LINE_BITS-1:0] line);
         int first;
         first = expected_bytes.size();
         case (kind)
            dlpe_pkg::KIND_BEGIN: begin
               cur_file = dlpe_pkg::FILE_BITS'(1);
               cur_line = dlpe_pkg::LINE_BITS'(1);
               prologue_seen = 0;
               put_set_address(addr);
               encode_row(file, line, 0);
            end
            dlpe_pkg::KIND_ROW: begin
               put_set_address(addr);
               if (!has_loc) begin
                  file = cur_file;
                  line = '0;
               end
               encode_row(file, line, 1);
            end
            dlpe_pkg::KIND_END: begin
               put_set_address(addr);
               put_byte(dlpe_pkg::OP_EXTENDED);
               put_byte(dlpe_pkg::EXT_END_SEQ_LEN);
               put_byte(dlpe_pkg::EXT_END_SEQUENCE);
            end
            default: ;
         endcase
         if (expected_bytes.size() > first) expected_last[expected_last.size() - 1] = 1'b1;
      endfunction

      // accepted output transfer: compare against the oldest expected byte
      function void check_byte(logic [7:0] value, logic last);
         logic [7:0] exp_value;
         bit exp_last;
         if (expected_bytes.size() == 0) begin
            $display("%0t unexpected byte: expected none actual %02h last %0b",
                     $time, value, last);
            errors++;
            return;
         end
         exp_value = expected_bytes.pop_front();
         exp_last = expected_last.pop_front();
         if (value !== exp_value) begin
            $display("%0t out_byte mismatch: expected %02h actual %02h",
                     $time, exp_value, value);
            errors++;
         end
         if (last !== exp_last) begin
            $display("%0t last mismatch: expected %0b actual %0b", $time, exp_last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = '0;
   logic [dlpe_pkg::ADDR_BITS-1:0] req_address = '0;
   logic req_has_location = 1'b0;
   logic [dlpe_pkg::FILE_BITS-1:0] req_file_index = '0;
   logic [dlpe_pkg::LINE_BITS-1:0] req_line_number = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_last;

   line_program_checker sb = new();
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int items_sent = 0;
   bit hold_start = 0;
   bit hold_done = 0;

   dwarf_line_program_encoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_has_location (req_has_location),
      .req_file_index   (req_file_index),
      .req_line_number  (req_line_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #1000000;
      $display("tb_dwarf_line_program_encoder: FAIL");
      $finish;
   end

   // transfer monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_item(req_kind, req_address, req_has_location, req_file_index,
                         req_line_number);
         if (rsp_valid && rsp_ready) sb.check_byte(rsp_out_byte, rsp_last);
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // offer one item, return at the edge where it is accepted
   task automatic send_item(input logic [1:0] kind,
                            input logic [dlpe_pkg::ADDR_BITS-1:0] addr,
                            input logic loc, input logic [dlpe_pkg::FILE_BITS-1:0] file,
                            input logic [dlpe_pkg::LINE_BITS-1:0] line);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_address <= addr;
      req_has_location <= loc;
      req_file_index <= file;
      req_line_number <= line;
      do @(posedge clock); while (!req_ready);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   // stop offering and wait until every expected byte has come out
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [dlpe_pkg::ADDR_BITS-1:0] rand_address();
      int r;
      r = $urandom_range(9);
      if (r == 0) return '1;
      if (r == 1) return dlpe_pkg::ADDR_BITS'($urandom_range(4095));
      return {$urandom, $urandom};
   endfunction

   // mostly files 1..3 so that repeats occur, sometimes wide or leb128 edge values
   function automatic logic [dlpe_pkg::FILE_BITS-1:0] rand_file();
      int r;
      r = $urandom_range(9);
      if (r < 6) return dlpe_pkg::FILE_BITS'($urandom_range(1, 3));
      if (r == 6) return dlpe_pkg::FILE_BITS'($urandom);
      if (r == 7) return '0;
      if (r == 8) return '1;
      return dlpe_pkg::FILE_BITS'($urandom_range(127, 128));
   endfunction

   function automatic logic [dlpe_pkg::LINE_BITS-1:0] rand_line();
      int r;
      r = $urandom_range(9);
      if (r < 5) return dlpe_pkg::LINE_BITS'($urandom_range(200));
      if (r < 7) return dlpe_pkg::LINE_BITS'($urandom);
      if (r == 7) return '0;
      if (r == 8) return '1;
      return dlpe_pkg::LINE_BITS'($urandom_range(60, 70));
   endfunction

   // one well-formed sequence with random content, or a stray item now and then
   task automatic send_random_sequence();
      int r;
      int rows;
      r = $urandom_range(9);
      if (r == 0) begin
         send_item(KIND_UNUSED, rand_address(), 1'($urandom_range(1)), rand_file(),
                   rand_line());
      end else if (r == 1) begin
         send_item(dlpe_pkg::KIND_ROW, rand_address(), 1'($urandom_range(1)), rand_file(),
                   rand_line());
      end else if (r == 2) begin
         send_item(dlpe_pkg::KIND_END, rand_address(), 1'($urandom_range(1)), rand_file(),
                   rand_line());
      end else begin
         rows = $urandom_range(1, 5);
         send_item(dlpe_pkg::KIND_BEGIN, rand_address(), 1'($urandom_range(1)),
                   rand_file(), rand_line());
         repeat (rows)
            send_item(dlpe_pkg::KIND_ROW, rand_address(), ($urandom_range(6) != 0),
                      rand_file(), rand_line());
         if ($urandom_range(7) != 0)
            send_item(dlpe_pkg::KIND_END, rand_address(), 1'($urandom_range(1)),
                      rand_file(), rand_line());
      end
   endtask

   // main sequence
   initial begin
      int target;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               sender_idle_pct = 36;
               receiver_idle_pct = 77;
            end
            1: begin
               sender_idle_pct = 77;
               receiver_idle_pct = 36;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase

         if (mode == 0) begin
            // row before any begin, against reset state
            send_item(dlpe_pkg::KIND_ROW, 64'h0123_4567_89ab_cdef, 1'b1, 16'd1, 24'd1);
            // minimal begin, then leb128 sign and length edges
            send_item(dlpe_pkg::KIND_BEGIN, 64'd0, 1'b1, 16'd1, 24'd1);
            send_item(dlpe_pkg::KIND_ROW, 64'h10, 1'b1, 16'd1, 24'd64);
            send_item(dlpe_pkg::KIND_ROW, 64'h20, 1'b1, 16'd1, 24'd128);
            send_item(dlpe_pkg::KIND_ROW, 64'h30, 1'b1, 16'd1, 24'd64);
            send_item(dlpe_pkg::KIND_ROW, 64'h40, 1'b1, 16'd1, 24'd63);
            // row without location goes to line zero
            send_item(dlpe_pkg::KIND_ROW, 64'h50, 1'b0, 16'd9, 24'd500);
            // largest file and line, then back to zero
            send_item(dlpe_pkg::KIND_ROW, '1, 1'b1, '1, '1);
            send_item(dlpe_pkg::KIND_ROW, 64'h60, 1'b1, 16'd0, 24'd0);
            send_item(dlpe_pkg::KIND_ROW, 64'h70, 1'b1, 16'd127, 24'd0);
            send_item(dlpe_pkg::KIND_ROW, 64'h80, 1'b1, 16'd128, 24'd0);
            send_item(dlpe_pkg::KIND_END, '1, 1'b1, 16'd5, 24'd5);
            // unused kind produces nothing
            send_item(KIND_UNUSED, {$urandom, $urandom}, 1'b1, '1, '1);
            // begin ignores has_location, the body start mark waits for a nonzero line
            send_item(dlpe_pkg::KIND_BEGIN, 64'h8000_0000_0000_0000, 1'b0, '1, '1);
            send_item(dlpe_pkg::KIND_ROW, 64'h90, 1'b0, 16'd3, 24'd3);
            send_item(dlpe_pkg::KIND_ROW, 64'ha0, 1'b1, '1, 24'd1);
            send_item(dlpe_pkg::KIND_ROW, 64'hb0, 1'b1, '1, 24'd2);
            send_item(dlpe_pkg::KIND_END, 64'hc0, 1'b0, 16'd0, 24'd0);
            // begin at line zero
            send_item(dlpe_pkg::KIND_BEGIN, 64'hd0, 1'b1, 16'd1, 24'd0);
            send_item(dlpe_pkg::KIND_ROW, 64'he0, 1'b1, 16'd1, 24'd0);
            send_item(dlpe_pkg::KIND_ROW, 64'hf0, 1'b1, 16'd1, 24'd66);
            send_item(dlpe_pkg::KIND_ROW, 64'h100, 1'b1, 16'd1, 24'd1);
            send_item(dlpe_pkg::KIND_END, 64'h110, 1'b1, 16'd1, 24'd1);
         end

         target = items_sent + ITEMS_PER_MODE;
         while (items_sent < target) begin
            // long receiver hold-off while the sender keeps offering
            if (mode == 2 && !hold_done) begin
               hold_start = 1;
               hold_done = 1;
            end
            send_random_sequence();
         end
         drain_results();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_dwarf_line_program_encoder: PASS");
      end else begin
         $display("tb_dwarf_line_program_encoder: FAIL");
      end
      $finish;
   end

endmodule
